// File: hdl/sfla_pkg.sv
// Shared types and state codes for the shortest-first least-load assigner.
`default_nettype none
package sfla_pkg;

   localparam int TIME_W = 32;
   localparam int TAG_W  = 8;
   localparam int MASK_W = 8;
   localparam int NIDX_W = 3;

   typedef struct packed {
      logic              kind;
      logic [NIDX_W-1:0] node_index;
      logic [TIME_W-1:0] time_left;
      logic [TAG_W-1:0]  task_tag;
      logic [MASK_W-1:0] fit_mask;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]  out_tag;
      logic [NIDX_W-1:0] out_node;
      logic              assigned;
      logic              overflow;
      logic              end_of_batch;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_est;
      logic [TAG_W-1:0]  tag;
      logic [MASK_W-1:0] mask;
   } task_type;

   // per-cycle command to every cell of the sort chain
   typedef struct packed {
      logic ins;
      logic shift;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_PLACE = 2'b10
   } state_type;

   localparam logic KIND_NODE = 1'b0;
   localparam logic KIND_TASK = 1'b1;

endpackage
`default_nettype wire

// File: hdl/sfla_cell.sv
// One cell of the sorted task chain: stable insert by time, left shift to drain.
`default_nettype none
module sfla_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire sfla_pkg::cell_cmd_type cmd,
   input  wire sfla_pkg::task_type new_task,
   input  wire sfla_pkg::task_type left_task,
   input  wire                     left_valid,
   input  wire                     left_push,
   input  wire sfla_pkg::task_type right_task,
   input  wire                     right_valid,
   output sfla_pkg::task_type      task_out,
   output logic                    valid_out,
   output logic                    push_out
);

   sfla_pkg::task_type task_ff, task_in;
   logic               valid_ff, valid_in;

   // entry moves right when the incoming time is strictly smaller (ties stay ahead)
   assign push_out  = valid_ff && (task_ff.time_est > new_task.time_est);
   assign task_out  = task_ff;
   assign valid_out = valid_ff;

   always_comb begin
      task_in  = task_ff;
      valid_in = valid_ff;
      if (cmd.shift) begin
         task_in  = right_task;
         valid_in = right_valid;
      end else if (cmd.ins) begin
         if (left_push) begin
            task_in  = left_task;
            valid_in = 1'b1;
         end else if ((!valid_ff || push_out) && left_valid) begin
            task_in  = new_task;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/sfla_pick.sv
// Least-loaded feasible node search: three-level compare tree, lowest index on ties.
`default_nettype none
module sfla_pick #(
   parameter int NUM_NODES = 8
) (
   input  wire [31:0]                  loads [NUM_NODES],
   input  wire [sfla_pkg::MASK_W-1:0]  mask,
   output logic                        found,
   output logic [sfla_pkg::NIDX_W-1:0] best
);

   localparam int LEAVES = 8;

   logic                        f0 [LEAVES];
   logic [31:0]                 l0 [LEAVES];
   logic                        f1 [4];
   logic [31:0]                 l1 [4];
   logic [sfla_pkg::NIDX_W-1:0] i1 [4];
   logic                        f2 [2];
   logic [31:0]                 l2 [2];
   logic [sfla_pkg::NIDX_W-1:0] i2 [2];

   // leaves at or above NUM_NODES hold no node and never fit
   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < NUM_NODES) begin : g_on
         assign f0[j] = mask[j];
         assign l0[j] = loads[j];
      end else begin : g_off
         assign f0[j] = 1'b0;
         assign l0[j] = '0;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (f0[2*k+1] && (!f0[2*k] || l0[2*k+1] < l0[2*k])) begin
            f1[k] = 1'b1;
            l1[k] = l0[2*k+1];
            i1[k] = sfla_pkg::NIDX_W'(2*k+1);
         end else begin
            f1[k] = f0[2*k];
            l1[k] = l0[2*k];
            i1[k] = sfla_pkg::NIDX_W'(2*k);
         end
      end
      for (int k = 0; k < 2; k++) begin
         if (f1[2*k+1] && (!f1[2*k] || l1[2*k+1] < l1[2*k])) begin
            f2[k] = 1'b1;
            l2[k] = l1[2*k+1];
            i2[k] = i1[2*k+1];
         end else begin
            f2[k] = f1[2*k];
            l2[k] = l1[2*k];
            i2[k] = i1[2*k];
         end
      end
      if (f2[1] && (!f2[0] || l2[1] < l2[0])) begin
         found = 1'b1;
         best  = i2[1];
      end else begin
         found = f2[0];
         best  = f2[0] ? i2[0] : '0;
      end
   end

endmodule
`default_nettype wire

// File: hdl/shortest_first_least_load_assigner_core.sv
// Top level: batch loader, sorted cell chain and greedy least-load placement.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | sfla_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | sfla_pkg::rsp_type
//
// Loading takes one item per cycle; each task is inserted into the chain in that cycle
// unless the chain is full. The closing task starts placement: one assignment per cycle
// from the chain head, set by the node compare tree and load update.
// req_stall is high during placement. A stalled rsp holds its result and placement waits.
// Reset is synchronous; it empties the chain and clears loads, count and drop flag.
`default_nettype none
module shortest_first_least_load_assigner_core #(
   parameter int MAX_TASKS = 32,
   parameter int NUM_NODES = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire sfla_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output sfla_pkg::rsp_type  rsp_payload
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   sfla_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  drop_ff, drop_in;
   logic [31:0]           loads_ff [NUM_NODES];
   logic [31:0]           loads_in [NUM_NODES];
   logic                  rsp_valid_ff, rsp_valid_in;
   sfla_pkg::rsp_type     rsp_ff, rsp_in;

   sfla_pkg::cell_cmd_type cmd;
   sfla_pkg::task_type     new_task;
   sfla_pkg::task_type     c_task  [MAX_TASKS];
   logic                   c_valid [MAX_TASKS];
   logic                   c_push  [MAX_TASKS];

   logic                   req_acc, emit, full, found;
   logic [sfla_pkg::NIDX_W-1:0] best;
   logic [32:0]            sum;

   assign req_stall   = (state_ff != sfla_pkg::ST_LOAD);
   assign req_acc     = req_valid && !req_stall;
   assign full        = (cnt_ff == CNT_W'(MAX_TASKS));
   assign emit        = (state_ff == sfla_pkg::ST_PLACE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign new_task.time_est = req_payload.time_left;
   assign new_task.tag      = req_payload.task_tag;
   assign new_task.mask     = req_payload.fit_mask;
   assign cmd.ins   = req_acc && (req_payload.kind == sfla_pkg::KIND_TASK) && !full;
   assign cmd.shift = emit;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      sfla_pkg::task_type lt, rt;
      logic lv, lp, rv;
      if (i == 0) begin : g_head
         assign lt = new_task;
         assign lv = 1'b1;
         assign lp = 1'b0;
      end else begin : g_mid
         assign lt = c_task[i-1];
         assign lv = c_valid[i-1];
         assign lp = c_push[i-1];
      end
      if (i == MAX_TASKS - 1) begin : g_tail
         assign rt = new_task;
         assign rv = 1'b0;
      end else begin : g_nxt
         assign rt = c_task[i+1];
         assign rv = c_valid[i+1];
      end
      sfla_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_task    (new_task),
         .left_task   (lt),
         .left_valid  (lv),
         .left_push   (lp),
         .right_task  (rt),
         .right_valid (rv),
         .task_out    (c_task[i]),
         .valid_out   (c_valid[i]),
         .push_out    (c_push[i])
      );
   end

   sfla_pick #(.NUM_NODES(NUM_NODES)) u_pick (
      .loads (loads_ff),
      .mask  (c_task[0].mask),
      .found (found),
      .best  (best)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      loads_in     = loads_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sum          = '0;
      if (req_acc) begin
         if (req_payload.kind == sfla_pkg::KIND_NODE) begin
            for (int n = 0; n < NUM_NODES; n++) begin
               if (32'(req_payload.node_index) == 32'(n)) begin
                  loads_in[n] = req_payload.time_left;
               end
            end
         end else begin
            if (full) begin
               drop_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (req_payload.last) begin
               state_in = sfla_pkg::ST_PLACE;
            end
         end
      end
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_tag      = c_task[0].tag;
         rsp_in.out_node     = found ? best : '0;
         rsp_in.assigned     = found;
         rsp_in.overflow     = drop_ff;
         rsp_in.end_of_batch = (cnt_ff == CNT_W'(1));
         for (int n = 0; n < NUM_NODES; n++) begin
            if (found && 32'(best) == 32'(n)) begin
               sum = {1'b0, loads_ff[n]} + {1'b0, c_task[0].time_est};
               loads_in[n] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            state_in = sfla_pkg::ST_LOAD;
            drop_in  = 1'b0;
            for (int n = 0; n < NUM_NODES; n++) begin
               loads_in[n] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= sfla_pkg::ST_LOAD;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < NUM_NODES; n++) begin
            loads_ff[n] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         loads_ff     <= loads_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/sfla_checker.sv
// Port-level checker for the assigner core, bound to the top level.
`default_nettype none
module sfla_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire sfla_pkg::req_type req_payload,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire sfla_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp transaction changed");

   a_busy_mid_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.end_of_batch |-> req_stall)
      else $error("req accepted while batch results pending");

   a_unassigned_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.assigned |-> rsp_payload.out_node == '0)
      else $error("unassigned result carries a node");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind shortest_first_least_load_assigner_core sfla_checker u_sfla_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
